### rtl/display_list_builder_core_macros.svh
// Assertion macros for the display list builder core.
`ifndef DISPLAY_LIST_BUILDER_CORE_MACROS_SVH
`define DISPLAY_LIST_BUILDER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DLB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define DLB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/dlb_pkg.sv
// Shared types, codes and control program for the display list builder.
package dlb_pkg;

    localparam logic [1:0] KIND_RESET  = 2'd0;
    localparam logic [1:0] KIND_BLANK  = 2'd1;
    localparam logic [1:0] KIND_LINE   = 2'd2;
    localparam logic [1:0] KIND_FINISH = 2'd3;

    localparam logic [7:0]  BLANK8_BYTE = 8'h70;
    localparam logic [7:0]  JVB_BYTE    = 8'h41;
    localparam logic [7:0]  NO_INDEX    = 8'hff;
    localparam logic [7:0]  INT_BIT     = 8'h80;
    localparam logic [7:0]  ADDR_BIT    = 8'h40;
    localparam logic [15:0] BASE_RESET  = 16'h9700;

    localparam logic [2:0] SEL_BLANK8  = 3'd0;
    localparam logic [2:0] SEL_TAIL    = 3'd1;
    localparam logic [2:0] SEL_MODE    = 3'd2;
    localparam logic [2:0] SEL_ADDR_LO = 3'd3;
    localparam logic [2:0] SEL_ADDR_HI = 3'd4;
    localparam logic [2:0] SEL_JVB     = 3'd5;
    localparam logic [2:0] SEL_BASE_LO = 3'd6;
    localparam logic [2:0] SEL_BASE_HI = 3'd7;

    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_SUB8  = 3'd1;
    localparam logic [2:0] OP_INTR  = 3'd2;
    localparam logic [2:0] OP_LATCH = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;

    localparam logic [1:0] FIN_NO     = 2'd0;
    localparam logic [1:0] FIN_YES    = 2'd1;
    localparam logic [1:0] FIN_NOADDR = 2'd2;

    localparam logic C_ALWAYS = 1'b0;
    localparam logic C_BIG    = 1'b1;

    localparam logic [3:0] ENT_RESET  = 4'd0;
    localparam logic [3:0] ENT_BLANK  = 4'd1;
    localparam logic [3:0] ENT_LINE   = 4'd3;
    localparam logic [3:0] ENT_FINISH = 4'd6;

    typedef struct packed {
        logic       cond;
        logic       emit;
        logic [2:0] sel;
        logic [1:0] fin;
        logic [2:0] op;
        logic       jmp;
        logic [3:0] tgt;
    } ctrl_t;

    typedef struct packed {
        logic big;
        logic has_addr;
    } flags_t;

    typedef struct packed {
        logic       emit;
        logic       last;
        logic [2:0] sel;
        logic [2:0] op;
    } step_t;

    function automatic ctrl_t rom_word(input logic [3:0] addr);
        ctrl_t w;
        w.cond = C_ALWAYS;
        w.emit = 1'b0;
        w.sel  = SEL_JVB;
        w.fin  = FIN_YES;
        w.op   = OP_NONE;
        w.jmp  = 1'b0;
        w.tgt  = 4'd0;
        case (addr)
            4'd0:
            begin
                w.op = OP_CLEAR;
            end
            4'd1:
            begin
                w.cond = C_BIG;
                w.emit = 1'b1;
                w.sel  = SEL_BLANK8;
                w.fin  = FIN_NO;
                w.op   = OP_SUB8;
                w.jmp  = 1'b1;
                w.tgt  = ENT_BLANK;
            end
            4'd2:
            begin
                w.emit = 1'b1;
                w.sel  = SEL_TAIL;
            end
            4'd3:
            begin
                w.emit = 1'b1;
                w.sel  = SEL_MODE;
                w.fin  = FIN_NOADDR;
                w.op   = OP_INTR;
            end
            4'd4:
            begin
                w.emit = 1'b1;
                w.sel  = SEL_ADDR_LO;
                w.fin  = FIN_NO;
            end
            4'd5:
            begin
                w.emit = 1'b1;
                w.sel  = SEL_ADDR_HI;
            end
            4'd6:
            begin
                w.emit = 1'b1;
                w.sel  = SEL_JVB;
                w.fin  = FIN_NO;
            end
            4'd7:
            begin
                w.emit = 1'b1;
                w.sel  = SEL_BASE_LO;
                w.fin  = FIN_NO;
            end
            4'd8:
            begin
                w.emit = 1'b1;
                w.sel  = SEL_BASE_HI;
                w.op   = OP_LATCH;
            end
            default:
            begin
                w.emit = 1'b0;
            end
        endcase
        return w;
    endfunction

    function automatic logic [3:0] entry_point(input logic [1:0] kind);
        logic [3:0] e;
        case (kind)
            KIND_RESET:  e = ENT_RESET;
            KIND_BLANK:  e = ENT_BLANK;
            KIND_LINE:   e = ENT_LINE;
            KIND_FINISH: e = ENT_FINISH;
            default:     e = ENT_RESET;
        endcase
        return e;
    endfunction

endpackage

### rtl/dlb_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
module dlb_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [1:0]      kind,
    input  logic            adv,
    input  dlb_pkg::flags_t flags,
    output logic            busy,
    output dlb_pkg::step_t  step
);

    logic          busy_reg;
    logic          busy_next;
    logic [3:0]    upc_reg;
    logic [3:0]    upc_next;
    dlb_pkg::ctrl_t word;
    logic          exec;
    logic          fin_true;
    logic          fire;

    assign word = dlb_pkg::rom_word(upc_reg);
    assign exec = (word.cond == dlb_pkg::C_ALWAYS) || flags.big;
    assign fire = busy_reg && adv && exec;

    always_comb
    begin
        case (word.fin)
            dlb_pkg::FIN_NO:     fin_true = 1'b0;
            dlb_pkg::FIN_YES:    fin_true = 1'b1;
            dlb_pkg::FIN_NOADDR: fin_true = !flags.has_addr;
            default:             fin_true = 1'b1;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        upc_next  = upc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            upc_next  = dlb_pkg::entry_point(kind);
        end
        else if (busy_reg && adv)
        begin
            if (!exec)
            begin
                upc_next = upc_reg + 4'd1;
            end
            else if (fin_true)
            begin
                busy_next = 1'b0;
            end
            else if (word.jmp)
            begin
                upc_next = word.tgt;
            end
            else
            begin
                upc_next = upc_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            upc_reg  <= 4'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            upc_reg  <= upc_next;
        end
    end

    assign busy      = busy_reg;
    assign step.emit = fire && word.emit;
    assign step.last = fin_true;
    assign step.sel  = word.sel;
    assign step.op   = fire ? word.op : dlb_pkg::OP_NONE;

endmodule

### rtl/display_list_builder_core.sv
// The first list byte is emitted by a sequencer step once the accepted command is registered
// into the step counter; each microcode step emits at most one byte into one output register.
// Bytes per request: reset none, mode line 1 or 3, finish 3, blank floor((n-1)/8) blank
// bytes of 0x70 followed by one tail byte (n of 0 counts as 1).
// A stalled output register holds the sequencer. Reset: asynchronous, active low;
// clears position, interrupt count, sets line total to 1 and base to 0x9700.
module display_list_builder_core (
    input  logic        clk,
    input  logic        rst_n,
    // kind [1:0]
    input  logic [1:0]  s_tuser,
    // line_mode [7:0], blank_lines [15:8], has_address [16], scan_address [32:17],
    // want_interrupt [33], zero [39:34]
    input  logic [39:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // list_byte [7:0], byte_position [15:8], interrupt_index [23:16],
    // interrupt_lines [31:24]
    output logic [31:0] m_tdata,
    output logic        m_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] cfg_data,
    input  logic        cfg_valid,
    output logic        cfg_ready
);

    logic            busy;
    logic            accept;
    logic            adv;
    dlb_pkg::flags_t flags;
    dlb_pkg::step_t  step;

    logic [1:0]  kind_reg;
    logic [7:0]  mode_reg;
    logic [7:0]  n_reg;
    logic [7:0]  n_next;
    logic        has_reg;
    logic [15:0] addr_reg;
    logic        want_reg;

    logic [15:0] base_reg;
    logic [7:0]  wp_reg;
    logic [7:0]  wp_next;
    logic [7:0]  cnt_reg;
    logic [7:0]  cnt_next;
    logic [7:0]  total_reg;
    logic [7:0]  total_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] out_data_reg;
    logic        out_last_reg;

    logic [7:0]  n_minus1;
    logic [7:0]  new_total;
    logic [7:0]  byte_val;
    logic [7:0]  idx_val;
    logic [7:0]  lines_val;

    assign s_tready  = !busy;
    assign accept    = s_tvalid && s_tready;
    assign adv       = !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    assign flags.big      = n_reg > 8'd8;
    assign flags.has_addr = has_reg;

    dlb_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .kind  (s_tuser),
        .adv   (adv),
        .flags (flags),
        .busy  (busy),
        .step  (step)
    );

    assign n_minus1  = n_reg - 8'd1;
    assign new_total = (cnt_reg != 8'd0) ? cnt_reg : 8'd1;

    always_comb
    begin
        case (step.sel)
            dlb_pkg::SEL_BLANK8:  byte_val = dlb_pkg::BLANK8_BYTE;
            dlb_pkg::SEL_TAIL:    byte_val = {1'b0, n_minus1[2:0], 4'b0000};
            dlb_pkg::SEL_MODE:    byte_val = mode_reg
                                           | (want_reg ? dlb_pkg::INT_BIT : 8'h00)
                                           | (has_reg ? dlb_pkg::ADDR_BIT : 8'h00);
            dlb_pkg::SEL_ADDR_LO: byte_val = addr_reg[7:0];
            dlb_pkg::SEL_ADDR_HI: byte_val = addr_reg[15:8];
            dlb_pkg::SEL_JVB:     byte_val = dlb_pkg::JVB_BYTE;
            dlb_pkg::SEL_BASE_LO: byte_val = base_reg[7:0];
            dlb_pkg::SEL_BASE_HI: byte_val = base_reg[15:8];
            default:              byte_val = 8'h00;
        endcase
    end

    assign idx_val   = ((step.sel == dlb_pkg::SEL_MODE) && want_reg) ? cnt_reg
                                                                      : dlb_pkg::NO_INDEX;
    assign lines_val = (kind_reg == dlb_pkg::KIND_FINISH) ? new_total : total_reg;

    always_comb
    begin
        n_next     = n_reg;
        wp_next    = wp_reg;
        cnt_next   = cnt_reg;
        total_next = total_reg;
        if (accept)
        begin
            n_next = (s_tdata[15:8] == 8'd0) ? 8'd1 : s_tdata[15:8];
        end
        if (step.emit)
        begin
            wp_next = wp_reg + 8'd1;
        end
        case (step.op)
            dlb_pkg::OP_NONE:  ;
            dlb_pkg::OP_SUB8:  n_next = n_reg - 8'd8;
            dlb_pkg::OP_INTR:
            begin
                if (want_reg && (cnt_reg != 8'hff))
                begin
                    cnt_next = cnt_reg + 8'd1;
                end
            end
            dlb_pkg::OP_LATCH: total_next = new_total;
            dlb_pkg::OP_CLEAR:
            begin
                wp_next    = 8'd0;
                cnt_next   = 8'd0;
                total_next = 8'd1;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= dlb_pkg::BASE_RESET;
            wp_reg        <= 8'd0;
            cnt_reg       <= 8'd0;
            total_reg     <= 8'd1;
            n_reg         <= 8'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                base_reg <= cfg_data;
            end
            wp_reg        <= wp_next;
            cnt_reg       <= cnt_next;
            total_reg     <= total_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= s_tuser;
            mode_reg <= s_tdata[7:0];
            has_reg  <= s_tdata[16];
            addr_reg <= s_tdata[32:17];
            want_reg <= s_tdata[33];
        end
        if (step.emit)
        begin
            out_data_reg <= {lines_val, idx_val, wp_reg, byte_val};
            out_last_reg <= step.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

`include "display_list_builder_core_macros.svh"

    `DLB_ASSERT_NXT(a_emit_shows, step.emit, m_tvalid, "emitted byte not presented")
    `DLB_ASSERT_NXT(a_wp_step, step.emit && (step.op != dlb_pkg::OP_CLEAR),
        wp_reg == $past(wp_reg) + 8'd1, "write position did not advance by one")
    `DLB_ASSERT_NXT(a_cnt_mono, step.op != dlb_pkg::OP_CLEAR,
        cnt_reg >= $past(cnt_reg), "interrupt count went down without clear")
    `DLB_ASSERT_IMP(a_no_emit_stall, out_valid_reg && !m_tready, !step.emit,
        "byte emitted while output held")

endmodule
